>>> sv/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg: shared types and constants for the integer to decimal text block
// Controller states, command/status bundles and ASCII codes.
// ----------------------------------------------------------------------------
package itda_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_MEASURE,
    ST_EMIT
  } state_t;

  // Binary bits consumed per conversion cycle
  localparam int DABBLE_BITS = 4;

  // ASCII codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // Field widths of the channels
  localparam int IN_VALUE_W = 32;
  localparam int CHAR_W     = 7;
  localparam int LENGTH_W   = 4;

  // Operation selector codes
  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture input item, start conversion
    logic step;     // one double-dabble step
    logic measure;  // count significant digits
    logic emit;     // load next character into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_done;  // current step is the final one
    logic emit_last;  // character being emitted is the last one
    logic out_free;   // output register can take a character
  } status_t;

endpackage

>>> sv/itda_ctrl.sv
// ----------------------------------------------------------------------------
// itda_ctrl: sequencing controller
// Walks each item through load, conversion steps, digit count and emission.
// ----------------------------------------------------------------------------
module itda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  itda_pkg::status_t status,
  output itda_pkg::cmd_t    cmd
);

  itda_pkg::state_t state;
  itda_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      itda_pkg::ST_IDLE: begin
        if (in_valid) state_next = itda_pkg::ST_CONVERT;
      end
      itda_pkg::ST_CONVERT: begin
        if (status.conv_done) state_next = itda_pkg::ST_MEASURE;
      end
      itda_pkg::ST_MEASURE: begin
        state_next = itda_pkg::ST_EMIT;
      end
      itda_pkg::ST_EMIT: begin
        if (status.out_free && status.emit_last) state_next = itda_pkg::ST_IDLE;
      end
      default: begin
        state_next = itda_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      itda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      itda_pkg::ST_CONVERT: begin
        cmd.step = 1'b1;
      end
      itda_pkg::ST_MEASURE: begin
        cmd.measure = 1'b1;
      end
      itda_pkg::ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> sv/itda_dpath.sv
// ----------------------------------------------------------------------------
// itda_dpath: conversion datapath
// Sign handling, multi-bit double-dabble, digit count and character output.
// ----------------------------------------------------------------------------
module itda_dpath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  itda_pkg::cmd_t                      cmd,
  output itda_pkg::status_t                   status,
  input  logic                                operation,
  input  logic [itda_pkg::IN_VALUE_W-1:0]     value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [itda_pkg::CHAR_W-1:0]         char_code,
  output logic [itda_pkg::LENGTH_W-1:0]       length,
  output logic                                last
);

  localparam int STEPS  = (VALUE_WIDTH + itda_pkg::DABBLE_BITS - 1) / itda_pkg::DABBLE_BITS;
  localparam int PAD_W  = STEPS * itda_pkg::DABBLE_BITS;
  localparam int NDIG   = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BCD_W  = 4 * NDIG;
  localparam int DIG_W  = $clog2(NDIG + 1);
  localparam int TOT_W  = DIG_W + 1;
  localparam int STEP_W = $clog2(STEPS);
  localparam int IN_W   = (VALUE_WIDTH < itda_pkg::IN_VALUE_W) ?
                          VALUE_WIDTH : itda_pkg::IN_VALUE_W;

  logic [PAD_W-1:0]  binary_shift;
  logic [BCD_W-1:0]  bcd_digits;
  logic [STEP_W-1:0] step_count;
  logic              negative_flag;
  logic [TOT_W-1:0]  emit_index;
  logic [DIG_W-1:0]  digit_total;

  logic [VALUE_WIDTH-1:0] v_ext;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       bcd_next;
  logic [PAD_W-1:0]       shift_next;
  logic [DIG_W-1:0]       digit_count;
  logic [TOT_W-1:0]       total;
  logic [TOT_W-1:0]       pos;
  logic [3:0]             digit_sel;
  logic [TOT_W+itda_pkg::LENGTH_W-1:0] total_wide;

  // Input value, sign and magnitude
  always_comb begin
    v_ext           = '0;
    v_ext[IN_W-1:0] = value[IN_W-1:0];
    neg_in          = (operation == itda_pkg::OP_SIGNED) && v_ext[VALUE_WIDTH-1];
    mag             = neg_in ? (~v_ext + 1'b1) : v_ext;
  end

  // Several double-dabble bits per cycle
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [PAD_W-1:0] s;
    b = bcd_digits;
    s = binary_shift;
    for (int k = 0; k < itda_pkg::DABBLE_BITS; k++) begin
      for (int i = 0; i < NDIG; i++) begin
        if (b[4*i +: 4] >= 4'd5) b[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
      b = {b[BCD_W-2:0], s[PAD_W-1]};
      s = {s[PAD_W-2:0], 1'b0};
    end
    bcd_next   = b;
    shift_next = s;
  end

  // Highest nonzero digit, at least one digit
  always_comb begin
    digit_count = DIG_W'(1);
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_digits[4*i +: 4] != 4'd0) digit_count = DIG_W'(i + 1);
    end
  end

  // Character selection
  always_comb begin
    total = TOT_W'(digit_total) + TOT_W'(negative_flag);
    pos   = total - TOT_W'(1) - emit_index;
    digit_sel = 4'd0;
    for (int i = 0; i < NDIG; i++) begin
      if (pos == TOT_W'(i)) digit_sel = bcd_digits[4*i +: 4];
    end
    total_wide = (TOT_W + itda_pkg::LENGTH_W)'(total);
  end

  assign status.conv_done = (step_count == STEP_W'(STEPS - 1));
  assign status.emit_last = ((emit_index + TOT_W'(1)) == total);
  assign status.out_free  = !out_valid || out_ready;

  // Working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
    end else if (cmd.load) begin
      step_count <= '0;
    end else if (cmd.step) begin
      step_count <= step_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      binary_shift  <= PAD_W'(mag);
      bcd_digits    <= '0;
      negative_flag <= neg_in;
    end else if (cmd.step) begin
      binary_shift <= shift_next;
      bcd_digits   <= bcd_next;
    end
    if (cmd.measure) begin
      digit_total <= digit_count;
      emit_index  <= '0;
    end else if (cmd.emit) begin
      emit_index <= emit_index + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (negative_flag && emit_index == '0) begin
        char_code <= itda_pkg::CHAR_MINUS;
      end else begin
        char_code <= itda_pkg::CHAR_ZERO + {3'b000, digit_sel};
      end
      length <= total_wide[itda_pkg::LENGTH_W-1:0];
      last   <= status.emit_last;
    end
  end

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("emit while output register is occupied");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (step_count < STEP_W'(STEPS - 1)) || status.conv_done)
    else $error("conversion step past its end");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (emit_index < total))
    else $error("character index beyond string length");

  a_out_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length != '0))
    else $error("character with zero length");
`endif

endmodule

>>> sv/integer_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii: 32-bit integer to decimal ASCII text
// Converts each value into its decimal characters, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: s_tdata carries the value, s_tuser selects unsigned (0)
//   or signed two's complement (1). One value is taken at a time.
//   Master channel: one item per character, '-' first for a negative signed
//   value, then the digits with no leading zeros; zero gives '0'. Each item
//   carries the string length, and m_tlast marks the final character.
//   Timing: each accepted value is converted by the double-dabble unit, four
//   bits per cycle, its digits are counted, and its characters are then
//   emitted one per cycle, pausing whenever m_tready holds them back.
//   s_tready is high only while no item is in progress; the last character
//   may still wait in the output register while the next value is taken.
//   A stall on m_tready holds the current character and pauses emission.
//   Reset (rst, synchronous) returns to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] char_code, [10:7] length, [15:11] zero
  output logic        m_tlast    // last
);

  itda_pkg::cmd_t    cmd;
  itda_pkg::status_t status;
  logic [itda_pkg::CHAR_W-1:0]   char_code;
  logic [itda_pkg::LENGTH_W-1:0] length;

  itda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  itda_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .operation (s_tuser),
    .value     (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .char_code (char_code),
    .length    (length),
    .last      (m_tlast)
  );

  assign m_tdata = {5'b00000, length, char_code};

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for integer_to_decimal_ascii
// Feeds 32-bit values with an unsigned/signed selector and checks every
// output character, its string length and the tlast marker against typed
// text or a decimal-text predictor. Directed rows cover the extremes, zero,
// the most negative signed value and digit-count boundaries. Random values
// follow. Both stream sides get random idle bursts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_RANDOM   = 260;
  localparam int TAIL_ITEMS   = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_CHARS    = 11;
  localparam int NUM_ROWS     = 22;

  // One expected output character
  typedef struct packed {
    logic [itda_pkg::CHAR_W-1:0]   code;
    logic [itda_pkg::LENGTH_W-1:0] length;
    logic                          last;
  } text_char_t;

  // Directed row: text of zero means "ask the predictor"
  typedef struct packed {
    logic                            op;
    logic [itda_pkg::IN_VALUE_W-1:0] val;
    logic [8*MAX_CHARS-1:0]          text;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  text_char_t  pending_chars[$];
  text_row_t   dir_rows[NUM_ROWS];
  int          errors = 0;
  int          values_sent = 0;
  int          negatives_sent = 0;
  int          chars_seen = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          tail_phase = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          tx_quiet = 1'b0;
  logic [MAX_CHARS:1] lengths_seen = '0;

  always #2 clk = ~clk;

  integer_to_decimal_ascii dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic longint unsigned pow10(input int k);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // Decimal text of one value: sign first, then digits, no leading zeros
  function automatic void predict_decimal(input logic op, input logic [31:0] val);
    logic [itda_pkg::CHAR_W-1:0] chars[MAX_CHARS];
    logic                        neg;
    logic [31:0]                 mag;
    int                          n;
    neg = (op == itda_pkg::OP_SIGNED) && val[31];
    mag = neg ? (~val + 32'd1) : val;
    n = 0;
    // digits come out least significant first
    do begin
      chars[n] = itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0);
    if (neg) begin
      chars[n] = itda_pkg::CHAR_MINUS;
      n++;
    end
    for (int i = n - 1; i >= 0; i--)
      pending_chars.push_back(text_char_t'{chars[i], itda_pkg::LENGTH_W'(n), i == 0});
  endfunction

  // Expected text typed into the table, right-justified ASCII
  function automatic void push_typed_text(input logic [8*MAX_CHARS-1:0] text);
    logic [itda_pkg::CHAR_W-1:0] chars[MAX_CHARS];
    int                          n;
    n = 0;
    for (int i = MAX_CHARS - 1; i >= 0; i--) begin
      if (text[i*8 +: 8] != 8'd0) begin
        chars[n] = text[i*8 +: itda_pkg::CHAR_W];
        n++;
      end
    end
    for (int i = 0; i < n; i++)
      pending_chars.push_back(text_char_t'{chars[i], itda_pkg::LENGTH_W'(n), i == n - 1});
  endfunction

  // Present one item and hold it until accepted
  task automatic send_value(input logic op, input logic [31:0] val,
                            input logic [8*MAX_CHARS-1:0] text);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    if (text != '0) push_typed_text(text);
    else predict_decimal(op, val);
    values_sent++;
    if (op == itda_pkg::OP_SIGNED && val[31]) negatives_sent++;
  endtask

  // Sender gap with noise on the data lines
  task automatic idle_sender(input int n);
    s_tvalid <= 1'b0;
    s_tdata  <= $urandom;
    s_tuser  <= 1'($urandom_range(0, 1));
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every pending character has come out
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  // Output check and receiver stall pattern
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch("character with nothing pending, code", m_tdata[6:0], 0);
      end else begin
        want = pending_chars.pop_front();
        lengths_seen[want.length] = 1'b1;
        if (m_tdata[6:0] != want.code)
          report_mismatch("char_code", m_tdata[6:0], want.code);
        if (m_tdata[10:7] != want.length)
          report_mismatch("length", m_tdata[10:7], want.length);
        if (m_tlast != want.last)
          report_mismatch("last", m_tlast, want.last);
        if (m_tdata[15:11] != 5'd0)
          report_mismatch("tdata padding", m_tdata[15:11], 0);
      end
    end
    if (cycles % 256 == 0) rx_quiet <= ($urandom_range(0, 2) == 0);
    if (tail_phase) begin
      stall_left <= 0;
      m_tready   <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 14);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still pending",
               cycles, pending_chars.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic            op;
    logic [31:0]     val;
    longint unsigned lo;
    longint unsigned hi;
    int              kind;
    int              k;
    int              width_count;

    dir_rows[0]  = '{itda_pkg::OP_UNSIGNED, 32'd0,          "0"};
    dir_rows[1]  = '{itda_pkg::OP_SIGNED,   32'd0,          "0"};
    dir_rows[2]  = '{itda_pkg::OP_UNSIGNED, 32'hFFFF_FFFF,  "4294967295"};
    dir_rows[3]  = '{itda_pkg::OP_SIGNED,   32'hFFFF_FFFF,  "-1"};
    dir_rows[4]  = '{itda_pkg::OP_SIGNED,   32'h8000_0000,  "-2147483648"};
    dir_rows[5]  = '{itda_pkg::OP_SIGNED,   32'h7FFF_FFFF,  "2147483647"};
    dir_rows[6]  = '{itda_pkg::OP_UNSIGNED, 32'h8000_0000,  "2147483648"};
    dir_rows[7]  = '{itda_pkg::OP_UNSIGNED, 32'h7FFF_FFFF,  "2147483647"};
    dir_rows[8]  = '{itda_pkg::OP_UNSIGNED, 32'd9,          "9"};
    dir_rows[9]  = '{itda_pkg::OP_UNSIGNED, 32'd10,         "10"};
    dir_rows[10] = '{itda_pkg::OP_SIGNED,   32'hFFFF_FFF6,  "-10"};
    dir_rows[11] = '{itda_pkg::OP_UNSIGNED, 32'd999999999,  '0};
    dir_rows[12] = '{itda_pkg::OP_UNSIGNED, 32'd1000000000, '0};
    dir_rows[13] = '{itda_pkg::OP_SIGNED,   32'h8000_0001,  '0};
    dir_rows[14] = '{itda_pkg::OP_UNSIGNED, 32'd1,          "1"};
    dir_rows[15] = '{itda_pkg::OP_SIGNED,   32'd1,          "1"};
    dir_rows[16] = '{itda_pkg::OP_UNSIGNED, 32'd12345,      '0};
    dir_rows[17] = '{itda_pkg::OP_SIGNED,   -32'sd99999,    '0};
    dir_rows[18] = '{itda_pkg::OP_UNSIGNED, 32'hAAAA_AAAA,  '0};
    dir_rows[19] = '{itda_pkg::OP_SIGNED,   32'h5555_5555,  '0};
    dir_rows[20] = '{itda_pkg::OP_UNSIGNED, 32'h0001_0000,  '0};
    dir_rows[21] = '{itda_pkg::OP_SIGNED,   32'hFFFF_0000,  '0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    foreach (dir_rows[i]) begin
      if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 15));
      send_value(dir_rows[i].op, dir_rows[i].val, dir_rows[i].text);
    end
    wait_drain();

    // Random values, weighted toward digit-count and sign boundaries
    for (int i = 0; i < NUM_RANDOM; i++) begin
      tail_phase = (i >= NUM_RANDOM - TAIL_ITEMS);
      if (i == NUM_RANDOM / 2) wait_drain();
      if (i % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      if (!tail_phase && !tx_quiet && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 15));

      kind = $urandom_range(0, 9);
      op   = 1'($urandom_range(0, 1));
      if (kind <= 3) begin
        val = $urandom;
      end else if (kind <= 6) begin
        k  = $urandom_range(1, 10);
        lo = (k == 1) ? 0 : pow10(k - 1);
        hi = pow10(k) - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        val = 32'(lo + ({32'($urandom), 32'($urandom)} % (hi - lo + 1)));
        if (op == itda_pkg::OP_SIGNED && $urandom_range(0, 1) == 1) val = -val;
      end else if (kind == 7) begin
        k   = $urandom_range(0, 9);
        val = 32'(pow10(k)) + 32'($urandom_range(0, 2)) - 32'd1;
        if (op == itda_pkg::OP_SIGNED && $urandom_range(0, 1) == 1) val = -val;
      end else if (kind == 8) begin
        case ($urandom_range(0, 4))
          0:       val = 32'd0;
          1:       val = 32'hFFFF_FFFF;
          2:       val = 32'h8000_0000;
          3:       val = 32'h7FFF_FFFF;
          default: val = 32'h8000_0001;
        endcase
      end else begin
        val = $urandom_range(0, 20);
        if (op == itda_pkg::OP_SIGNED && $urandom_range(0, 1) == 1) val = -val;
      end
      send_value(op, val, '0);
    end
    s_tvalid <= 1'b0;

    // Let the last strings come out, then watch for strays
    do @(posedge clk); while (pending_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    width_count = $countones(lengths_seen);
    $display("Converted %0d values (%0d signed negatives) into %0d characters",
             values_sent, negatives_sent, chars_seen);
    $display("String lengths seen: %0d of %0d, with random stalls on both sides",
             width_count, MAX_CHARS);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/itda_pkg.sv
sv/itda_ctrl.sv
sv/itda_dpath.sv
sv/integer_to_decimal_ascii.sv
tb/tb_top.sv
